FILE: rtl/blg_pkg.sv
// blg_pkg: constants and derived reciprocal factors for the battery level gauge
// no dependencies; imported by blg_history and battery_level_gauge
`timescale 1ns / 1ps

package blg_pkg;

    // field widths
    localparam int ADC_W = 12;
    localparam int PCT_W = 7;
    localparam int MV_W  = 12;

    // conversion constants
    localparam int unsigned ADC_FULL    = 4095;
    localparam int unsigned VREF_MV     = 3300;
    localparam int unsigned BATT_MIN_MV = 3300;
    localparam int unsigned BATT_MAX_MV = 3900;
    localparam int unsigned PCT_FULL    = 100;
    localparam int unsigned WINDOW_DEF  = 10;

    // divide by the window: n * ceil(2^20 / W) >> 20 is exact for n < 2^16, W <= 16
    localparam int DIV_SHIFT = 20;

    // scale to half millivolts: avg * ceil(VREF * 2^24 / FULL) >> 24, exact for avg < 2^12
    localparam int SCALE_SHIFT = 24;
    localparam longint unsigned SCALE_MUL_L =
        ((longint'(VREF_MV) << SCALE_SHIFT) + longint'(ADC_FULL) - 1) / longint'(ADC_FULL);
    localparam int unsigned SCALE_MUL   = int'(SCALE_MUL_L);
    localparam int          SCALE_MUL_W = $clog2(SCALE_MUL + 1);

    // clamp window on the half value (before doubling)
    localparam int unsigned HALF_MIN = BATT_MIN_MV / 2;
    localparam int unsigned HALF_MAX = BATT_MAX_MV / 2;
    localparam int unsigned OFS_MAX  = HALF_MAX - HALF_MIN;
    localparam int          OFS_W    = $clog2(OFS_MAX + 1);

    // percent = offset / step, done as offset * ceil(2^11 / step) >> 11
    localparam int unsigned PCT_STEP  = OFS_MAX / PCT_FULL;
    localparam int          PCT_SHIFT = 11;
    localparam int unsigned PCT_MUL   = ((1 << PCT_SHIFT) + PCT_STEP - 1) / PCT_STEP;
    localparam int          PCT_MUL_W = $clog2(PCT_MUL + 1);

endpackage

FILE: rtl/battery_level_gauge.sv
// battery_level_gauge: moving-average battery gauge, four-register pipeline
// depends on blg_pkg and blg_history
`timescale 1ns / 1ps
//
// channel   direction  handshake                     payload
// -------   ---------  ----------------------------  ------------------------------------
// in        sink       i_in_valid / o_in_ready       i_adc_sample, i_charge_pin_level
// out       source     o_out_valid / i_out_ready     o_percent, o_charging, o_battery_mv
// cfg       sink       i_cfg_valid / o_cfg_ready     i_cfg_monitor_present
//
// One item per cycle while i_out_ready is high; o_out_valid is the last stage's valid.
// The stages are: window sum, divide by window, scale and clamp, percent and output.
// Each stage has its own valid bit and loads when empty or when the next stage moves,
// so input is taken while a result waits, until the pipeline is full.
// Synchronous active-low reset empties the pipeline, reloads the history and sets
// the monitor bit; cfg writes are always taken.

module battery_level_gauge #(
    parameter int WINDOW = blg_pkg::WINDOW_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [blg_pkg::ADC_W-1:0] i_adc_sample,
    input  logic                      i_charge_pin_level,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [blg_pkg::PCT_W-1:0] o_percent,
    output logic                      o_charging,
    output logic [blg_pkg::MV_W-1:0]  o_battery_mv,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_monitor_present
);
    import blg_pkg::*;

    localparam int SUM_W     = $clog2(WINDOW * ADC_FULL + 1);
    localparam int unsigned DIV_MUL = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int DIV_MUL_W = $clog2(DIV_MUL + 1);
    localparam int DIV_P_W   = SUM_W + DIV_MUL_W;
    localparam int SCL_P_W   = ADC_W + SCALE_MUL_W;
    localparam int PCT_P_W   = OFS_W + PCT_MUL_W;

    logic r_monitor_present;

    logic r1_vld, r2_vld, r3_vld, r4_vld;
    logic w1_rdy, w2_rdy, w3_rdy, w4_rdy;
    logic w_in_acc;

    logic [SUM_W-1:0]   w_sum;
    logic [SUM_W-1:0]   r1_sum;
    logic               r1_pin, r1_mon;
    logic [DIV_P_W-1:0] w_div_p;
    logic [ADC_W-1:0]   r2_avg;
    logic               r2_pin, r2_mon;
    logic [SCL_P_W-1:0] w_scl_p;
    logic [ADC_W-1:0]   w_half;
    logic [OFS_W-1:0]   n3_ofs;
    logic [OFS_W-1:0]   r3_ofs;
    logic               r3_pin, r3_mon;
    logic [PCT_P_W-1:0] w_pct_p;
    logic [PCT_W-1:0]   w_pct;
    logic [PCT_W-1:0]   n4_pct;
    logic               n4_chg;
    logic [MV_W-1:0]    n4_mv;
    logic [PCT_W-1:0]   r4_pct;
    logic               r4_chg;
    logic [MV_W-1:0]    r4_mv;

    // config register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_monitor_present <= 1'b1;
        end else if (i_cfg_valid) begin
            r_monitor_present <= i_cfg_monitor_present;
        end
    end

    // stage ready chain: a stage loads when empty or when it empties this cycle
    assign w4_rdy     = !r4_vld || i_out_ready;
    assign w3_rdy     = !r3_vld || w4_rdy;
    assign w2_rdy     = !r2_vld || w3_rdy;
    assign w1_rdy     = !r1_vld || w2_rdy;
    assign o_in_ready = w1_rdy;
    assign w_in_acc   = i_in_valid && w1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (w1_rdy) r1_vld <= i_in_valid;
            if (w2_rdy) r2_vld <= r1_vld;
            if (w3_rdy) r3_vld <= r2_vld;
            if (w4_rdy) r4_vld <= r3_vld;
        end
    end

    // sample history; only measured items shift it
    blg_history #(
        .WINDOW (WINDOW)
    ) u_history (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_in_acc && r_monitor_present),
        .i_sample (i_adc_sample),
        .o_sum    (w_sum)
    );

    // stage 1: window sum
    always_ff @(posedge i_clk) begin
        if (w1_rdy && i_in_valid) begin
            r1_sum <= w_sum;
            r1_pin <= i_charge_pin_level;
            r1_mon <= r_monitor_present;
        end
    end

    // stage 2: average by reciprocal multiply
    assign w_div_p = DIV_P_W'(r1_sum) * DIV_P_W'(DIV_MUL);

    always_ff @(posedge i_clk) begin
        if (w2_rdy && r1_vld) begin
            r2_avg <= w_div_p[DIV_SHIFT +: ADC_W];
            r2_pin <= r1_pin;
            r2_mon <= r1_mon;
        end
    end

    // stage 3: scale to half millivolts and clamp to the battery range
    assign w_scl_p = SCL_P_W'(r2_avg) * SCL_P_W'(SCALE_MUL);
    assign w_half  = w_scl_p[SCALE_SHIFT +: ADC_W];

    always_comb begin
        if (w_half < ADC_W'(HALF_MIN)) begin
            n3_ofs = '0;
        end else if (w_half > ADC_W'(HALF_MAX)) begin
            n3_ofs = OFS_W'(OFS_MAX);
        end else begin
            n3_ofs = OFS_W'(w_half - ADC_W'(HALF_MIN));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w3_rdy && r2_vld) begin
            r3_ofs <= n3_ofs;
            r3_pin <= r2_pin;
            r3_mon <= r2_mon;
        end
    end

    // stage 4: percent, charge flag, millivolts; fixed values when monitor is off
    assign w_pct_p = PCT_P_W'(r3_ofs) * PCT_P_W'(PCT_MUL);
    assign w_pct   = w_pct_p[PCT_SHIFT +: PCT_W];

    always_comb begin
        if (r3_mon) begin
            n4_pct = w_pct;
            n4_chg = (w_pct != PCT_W'(PCT_FULL)) && !r3_pin;
            n4_mv  = MV_W'(BATT_MIN_MV) + MV_W'({r3_ofs, 1'b0});
        end else begin
            n4_pct = PCT_W'(PCT_FULL);
            n4_chg = 1'b0;
            n4_mv  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w4_rdy && r3_vld) begin
            r4_pct <= n4_pct;
            r4_chg <= n4_chg;
            r4_mv  <= n4_mv;
        end
    end

    assign o_out_valid  = r4_vld;
    assign o_percent    = r4_pct;
    assign o_charging   = r4_chg;
    assign o_battery_mv = r4_mv;

    // an empty output stage means every stage can take an item
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output stage");

    // a full battery never reports charging
    a_no_charge_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_charging |-> o_percent != PCT_W'(PCT_FULL))
        else $error("charging flagged at full charge");

    // measured voltage stays inside the clamp range
    a_mv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_battery_mv != '0 |->
            o_battery_mv >= MV_W'(BATT_MIN_MV) && o_battery_mv <= MV_W'(BATT_MAX_MV))
        else $error("battery voltage outside clamp range");

    // zero voltage only comes with the fixed full-battery result
    a_absent_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_battery_mv == '0 |-> o_percent == PCT_W'(PCT_FULL) && !o_charging)
        else $error("bad result for absent monitor");

endmodule

FILE: rtl/blg_history.sv
// blg_history: shift line of previous samples with a running sum
// depends on blg_pkg
`timescale 1ns / 1ps

module blg_history #(
    parameter int WINDOW = blg_pkg::WINDOW_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_shift,
    input  logic [blg_pkg::ADC_W-1:0]                     i_sample,
    output logic [$clog2(WINDOW * blg_pkg::ADC_FULL + 1)-1:0] o_sum
);
    import blg_pkg::*;

    localparam int DEPTH = WINDOW - 1;
    localparam int SUM_W = $clog2(WINDOW * ADC_FULL + 1);

    logic [ADC_W-1:0] r_hist [DEPTH];
    logic [ADC_W-1:0] n_hist [DEPTH];
    logic [SUM_W-1:0] r_hist_sum;
    logic [SUM_W-1:0] n_hist_sum;

    // sum of the new sample and all stored samples
    assign o_sum = r_hist_sum + SUM_W'(i_sample);

    // new sample enters at the front, the oldest drops out of the sum
    always_comb begin
        n_hist[0] = i_sample;
        for (int k = 1; k < DEPTH; k++) begin
            n_hist[k] = r_hist[k-1];
        end
        n_hist_sum = o_sum - SUM_W'(r_hist[DEPTH-1]);
    end

    // history registers; reset is full scale at the front, zeros behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_hist[k] <= (k == 0) ? ADC_W'(ADC_FULL) : '0;
            end
            r_hist_sum <= SUM_W'(ADC_FULL);
        end else if (i_shift) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_hist[k] <= n_hist[k];
            end
            r_hist_sum <= n_hist_sum;
        end
    end

endmodule
